FILE: rtl/qgsu_pkg.sv
// Shared types and constants for the qubit gate state update block.
// Holds the action codes, controller states, gate coefficient record and
// pipeline tag. Depends on nothing.
`default_nettype none

package qgsu_pkg;

   // Fixed widths of the item fields.
   localparam int ACTION_W  = 3;
   localparam int TARGET_W  = 10;
   localparam int FIELD_W   = 16;
   localparam int NQ_W      = 4;
   localparam int FRAC_BITS = 14;

   // Qubit count after reset.
   localparam logic [NQ_W-1:0] NQ_RESET = 4'd10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD     = 3'd0,
      ACT_READ     = 3'd1,
      ACT_GATE_ONE = 3'd2,
      ACT_GATE_ALL = 3'd3,
      ACT_FLIP     = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_FLIP_WAIT,
      ST_GATE,
      ST_GATE_DRAIN,
      ST_COPY,
      ST_COPY_DRAIN,
      ST_RESP
   } state_type;

   typedef logic signed [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type re;
      field_type im;
   } coef_type;

   typedef struct packed {
      coef_type g00;
      coef_type g01;
      coef_type g10;
      coef_type g11;
   } gate_type;

   // Tag that travels with each amplitude through the gate datapath.
   typedef struct packed {
      logic valid;
      logic row;
   } mac_tag_type;

endpackage

`default_nettype wire

FILE: rtl/qgsu_req_if.sv
// Request channel of the qubit gate state update block.
// Carries one item per beat. Depends on qgsu_pkg.
`default_nettype none

interface qgsu_req_if import qgsu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TARGET_W-1:0] target;
   field_type           amp_re;
   field_type           amp_im;
   field_type           g00_re;
   field_type           g00_im;
   field_type           g01_re;
   field_type           g01_im;
   field_type           g10_re;
   field_type           g10_im;
   field_type           g11_re;
   field_type           g11_im;

   modport source (output valid, action, target, amp_re, amp_im, g00_re, g00_im,
                   g01_re, g01_im, g10_re, g10_im, g11_re, g11_im, input ready);
   modport sink (input valid, action, target, amp_re, amp_im, g00_re, g00_im,
                 g01_re, g01_im, g10_re, g10_im, g11_re, g11_im, output ready);
endinterface

`default_nettype wire

FILE: rtl/qgsu_rsp_if.sv
// Response channel of the qubit gate state update block.
// Carries one result per beat. Depends on qgsu_pkg.
`default_nettype none

interface qgsu_rsp_if import qgsu_pkg::*; ();
   logic                valid;
   logic                ready;
   field_type           out_re;
   field_type           out_im;
   logic [ACTION_W-1:0] done_action;

   modport source (output valid, out_re, out_im, done_action, input ready);
   modport sink (input valid, out_re, out_im, done_action, output ready);
endinterface

`default_nettype wire

FILE: rtl/qgsu_csr_if.sv
// Configuration write channel of the qubit gate state update block.
// Carries the qubit count register. Depends on qgsu_pkg.
`default_nettype none

interface qgsu_csr_if import qgsu_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [NQ_W-1:0] num_qubits;

   modport source (output valid, num_qubits, input ready);
   modport sink (input valid, num_qubits, output ready);
endinterface

`default_nettype wire

FILE: rtl/qgsu_store.sv
// Amplitude and scratch memories of the qubit gate state update block.
// Amplitude memory has one write and two read ports, scratch one of each;
// all reads are registered. Depends on nothing.
`default_nettype none

module qgsu_store #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    amp_we,
   input  logic [MAX_QUBITS-1:0]   amp_waddr,
   input  logic [2*AMP_BITS-1:0]   amp_wdata,
   input  logic [MAX_QUBITS-1:0]   amp_raddr_a,
   input  logic [MAX_QUBITS-1:0]   amp_raddr_b,
   output logic [2*AMP_BITS-1:0]   amp_rdata_a,
   output logic [2*AMP_BITS-1:0]   amp_rdata_b,
   input  logic                    scr_we,
   input  logic [MAX_QUBITS-1:0]   scr_waddr,
   input  logic [2*AMP_BITS-1:0]   scr_wdata,
   input  logic [MAX_QUBITS-1:0]   scr_raddr,
   output logic [2*AMP_BITS-1:0]   scr_rdata
);

   localparam int DEPTH = 1 << MAX_QUBITS;
   localparam int DW    = 2 * AMP_BITS;

   logic [DW-1:0] amp_mem [DEPTH];
   logic [DW-1:0] scr_mem [DEPTH];
   logic [DW-1:0] rd_a_ff;
   logic [DW-1:0] rd_b_ff;
   logic [DW-1:0] rd_s_ff;

   // Amplitude memory: the entry is packed as real part over imaginary part.
   always_ff @(posedge clock) begin
      if (amp_we) begin
         amp_mem[amp_waddr] <= amp_wdata;
      end
      rd_a_ff <= amp_mem[amp_raddr_a];
      rd_b_ff <= amp_mem[amp_raddr_b];
   end

   // Scratch memory holds the new state while a gate pass is in progress.
   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_waddr] <= scr_wdata;
      end
      rd_s_ff <= scr_mem[scr_raddr];
   end

   assign amp_rdata_a = rd_a_ff;
   assign amp_rdata_b = rd_b_ff;
   assign scr_rdata   = rd_s_ff;

endmodule

`default_nettype wire

FILE: rtl/qgsu_mac.sv
// Complex gate datapath of the qubit gate state update block.
// Multiplies a gate row by an amplitude pair, rounds and saturates the sums
// and writes the result to scratch. Depends on qgsu_pkg.
`default_nettype none

module qgsu_mac import qgsu_pkg::*; #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mac_tag_type           issue_tag,
   input  logic [MAX_QUBITS-1:0] issue_idx,
   input  gate_type              gate,
   input  logic [2*AMP_BITS-1:0] s0_data,
   input  logic [2*AMP_BITS-1:0] s1_data,
   output logic                  busy,
   output logic                  scr_we,
   output logic [MAX_QUBITS-1:0] scr_waddr,
   output logic [2*AMP_BITS-1:0] scr_wdata
);

   localparam int DW = 2 * AMP_BITS;
   localparam int PW = FIELD_W + AMP_BITS;
   localparam int SW = PW + 2;
   localparam int RW = SW - FRAC_BITS;

   localparam logic signed [SW-1:0] ROUND_C =
      {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [RW-1:0] SAT_MAX =
      {{(RW-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

   mac_tag_type           tag1_ff;
   logic [MAX_QUBITS-1:0] idx1_ff;
   logic                  v2_ff;
   logic [MAX_QUBITS-1:0] idx2_ff;
   logic signed [PW-1:0]  prod_in [8];
   logic signed [PW-1:0]  prod_ff [8];

   coef_type                   ca;
   coef_type                   cc;
   logic signed [AMP_BITS-1:0] s0_re;
   logic signed [AMP_BITS-1:0] s0_im;
   logic signed [AMP_BITS-1:0] s1_re;
   logic signed [AMP_BITS-1:0] s1_im;
   logic signed [SW-1:0]       acc_re;
   logic signed [SW-1:0]       acc_im;
   logic signed [SW-1:0]       rnd_re;
   logic signed [SW-1:0]       rnd_im;
   logic signed [RW-1:0]       sh_re;
   logic signed [RW-1:0]       sh_im;
   logic [AMP_BITS-1:0]        sat_re;
   logic [AMP_BITS-1:0]        sat_im;

   // Stage one: the memory data arrives; pick the gate row and multiply.
   always_comb begin
      s0_re = s0_data[DW-1:AMP_BITS];
      s0_im = s0_data[AMP_BITS-1:0];
      s1_re = s1_data[DW-1:AMP_BITS];
      s1_im = s1_data[AMP_BITS-1:0];
      ca    = tag1_ff.row ? gate.g10 : gate.g00;
      cc    = tag1_ff.row ? gate.g11 : gate.g01;
      prod_in[0] = ca.re * s0_re;
      prod_in[1] = ca.im * s0_im;
      prod_in[2] = cc.re * s1_re;
      prod_in[3] = cc.im * s1_im;
      prod_in[4] = ca.re * s0_im;
      prod_in[5] = ca.im * s0_re;
      prod_in[6] = cc.re * s1_im;
      prod_in[7] = cc.im * s1_re;
   end

   // Stage two: exact sums, round half up, saturate.
   always_comb begin
      acc_re = SW'(prod_ff[0]) - SW'(prod_ff[1]) + SW'(prod_ff[2]) - SW'(prod_ff[3]);
      acc_im = SW'(prod_ff[4]) + SW'(prod_ff[5]) + SW'(prod_ff[6]) + SW'(prod_ff[7]);
      rnd_re = acc_re + ROUND_C;
      rnd_im = acc_im + ROUND_C;
      sh_re  = rnd_re[SW-1:FRAC_BITS];
      sh_im  = rnd_im[SW-1:FRAC_BITS];
      if (sh_re > SAT_MAX) begin
         sat_re = SAT_MAX[AMP_BITS-1:0];
      end else if (sh_re < SAT_MIN) begin
         sat_re = SAT_MIN[AMP_BITS-1:0];
      end else begin
         sat_re = sh_re[AMP_BITS-1:0];
      end
      if (sh_im > SAT_MAX) begin
         sat_im = SAT_MAX[AMP_BITS-1:0];
      end else if (sh_im < SAT_MIN) begin
         sat_im = SAT_MIN[AMP_BITS-1:0];
      end else begin
         sat_im = sh_im[AMP_BITS-1:0];
      end
   end

   // Pipeline valid bits and tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         v2_ff   <= 1'b0;
      end else begin
         tag1_ff <= issue_tag;
         v2_ff   <= tag1_ff.valid;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx1_ff <= issue_idx;
      idx2_ff <= idx1_ff;
      prod_ff <= prod_in;
   end

   assign busy      = tag1_ff.valid | v2_ff;
   assign scr_we    = v2_ff;
   assign scr_waddr = idx2_ff;
   assign scr_wdata = {sat_re, sat_im};

endmodule

`default_nettype wire

FILE: rtl/qgsu_ctrl.sv
// Sequencer of the qubit gate state update block.
// Runs the clearing pass, the single-entry actions and the gate and copy
// sweeps, and owns the channel handshakes. Depends on qgsu_pkg and the
// channel interfaces.
`default_nettype none

module qgsu_ctrl import qgsu_pkg::*; #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   qgsu_req_if.sink              req_bus,
   qgsu_rsp_if.source            rsp_bus,
   qgsu_csr_if.sink              csr_bus,
   output logic                  amp_we,
   output logic [MAX_QUBITS-1:0] amp_waddr,
   output logic [2*AMP_BITS-1:0] amp_wdata,
   output logic [MAX_QUBITS-1:0] amp_raddr_a,
   output logic [MAX_QUBITS-1:0] amp_raddr_b,
   input  logic [2*AMP_BITS-1:0] amp_rdata_a,
   output logic [MAX_QUBITS-1:0] scr_raddr,
   input  logic [2*AMP_BITS-1:0] scr_rdata,
   output mac_tag_type           issue_tag,
   output logic [MAX_QUBITS-1:0] issue_idx,
   output gate_type              gate,
   input  logic                  mac_busy
);

   localparam int ADDR_W = MAX_QUBITS;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int DW     = 2 * AMP_BITS;
   localparam int NW     = $clog2(MAX_QUBITS + 1);
   localparam int CW     = ADDR_W + 1;
   localparam int XW     = ((AMP_BITS > FIELD_W) ? AMP_BITS : FIELD_W) + 1;

   localparam logic signed [XW-1:0] AMP_MAX_X =
      {{(XW-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
   localparam logic signed [XW-1:0] AMP_MIN_X = ~AMP_MAX_X;

   // Saturate a widened value to the stored amplitude width.
   function automatic logic [AMP_BITS-1:0] sat_x(input logic signed [XW-1:0] v);
      logic [AMP_BITS-1:0] r;
      if (v > AMP_MAX_X) begin
         r = AMP_MAX_X[AMP_BITS-1:0];
      end else if (v < AMP_MIN_X) begin
         r = AMP_MIN_X[AMP_BITS-1:0];
      end else begin
         r = v[AMP_BITS-1:0];
      end
      return r;
   endfunction

   state_type           state_ff,     state_in;
   logic [CW-1:0]       cnt_ff,       cnt_in;
   logic [NW-1:0]       q_ff,         q_in;
   logic [NQ_W-1:0]     nq_ff,        nq_in;
   logic [ACTION_W-1:0] act_ff,       act_in;
   logic [TARGET_W-1:0] target_ff,    target_in;
   field_type           amp_re_ff,    amp_re_in;
   field_type           amp_im_ff,    amp_im_in;
   gate_type            gate_ff,      gate_in;
   field_type           res_re_ff,    res_re_in;
   field_type           res_im_ff,    res_im_in;
   logic                copy_v_ff,    copy_v_in;
   logic [ADDR_W-1:0]   copy_addr_ff, copy_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   field_type           rsp_re_ff,    rsp_re_in;
   field_type           rsp_im_ff,    rsp_im_in;
   logic [ACTION_W-1:0] rsp_act_ff,   rsp_act_in;

   logic [NW-1:0]              n_act;
   logic [CW-1:0]              size;
   logic [CW-1:0]              last_cnt;
   logic [ADDR_W-1:0]          idx;
   logic [NW-1:0]              pos;
   logic [ADDR_W-1:0]          qmask;
   logic [ADDR_W-1:0]          cur;
   logic signed [AMP_BITS-1:0] rd_re;
   logic signed [AMP_BITS-1:0] rd_im;
   logic signed [XW-1:0]       ext_re;
   logic signed [XW-1:0]       ext_im;

   // Active qubit count, state size, entry index and the mask of the qubit bit.
   always_comb begin
      if (nq_ff == '0) begin
         n_act = NW'(1);
      end else if (int'(nq_ff) > MAX_QUBITS) begin
         n_act = NW'(MAX_QUBITS);
      end else begin
         n_act = NW'(nq_ff);
      end
      size     = CW'(1) << n_act;
      last_cnt = size - CW'(1);
      idx      = ADDR_W'(target_ff) & last_cnt[ADDR_W-1:0];
      pos      = n_act - NW'(1) - q_ff;
      qmask    = ADDR_W'(1) << pos;
      cur      = cnt_ff[ADDR_W-1:0];
      rd_re    = amp_rdata_a[DW-1:AMP_BITS];
      rd_im    = amp_rdata_a[AMP_BITS-1:0];
      ext_re   = XW'(rd_re);
      ext_im   = XW'(rd_im);
   end

   // Next state, memory ports and result capture.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      nq_in        = nq_ff;
      act_in       = act_ff;
      target_in    = target_ff;
      amp_re_in    = amp_re_ff;
      amp_im_in    = amp_im_ff;
      gate_in      = gate_ff;
      res_re_in    = res_re_ff;
      res_im_in    = res_im_ff;
      copy_v_in    = 1'b0;
      copy_addr_in = cur;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_act_in   = rsp_act_ff;
      amp_we       = copy_v_ff;
      amp_waddr    = copy_addr_ff;
      amp_wdata    = scr_rdata;
      amp_raddr_a  = idx;
      amp_raddr_b  = cur | qmask;
      scr_raddr    = cur;
      issue_tag    = '0;
      issue_idx    = cur;

      if (csr_bus.valid) begin
         nq_in = csr_bus.num_qubits;
      end

      case (state_ff)
         ST_CLEAR: begin
            amp_we    = 1'b1;
            amp_waddr = cur;
            amp_wdata = '0;
            if (cnt_ff == CW'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               act_in         = req_bus.action;
               target_in      = req_bus.target;
               amp_re_in      = req_bus.amp_re;
               amp_im_in      = req_bus.amp_im;
               gate_in.g00.re = req_bus.g00_re;
               gate_in.g00.im = req_bus.g00_im;
               gate_in.g01.re = req_bus.g01_re;
               gate_in.g01.im = req_bus.g01_im;
               gate_in.g10.re = req_bus.g10_re;
               gate_in.g10.im = req_bus.g10_im;
               gate_in.g11.re = req_bus.g11_re;
               gate_in.g11.im = req_bus.g11_im;
               res_re_in      = '0;
               res_im_in      = '0;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (act_ff)
               ACT_LOAD: begin
                  amp_we    = 1'b1;
                  amp_waddr = idx;
                  amp_wdata = {sat_x(XW'(amp_re_ff)), sat_x(XW'(amp_im_ff))};
                  state_in  = ST_RESP;
               end
               ACT_READ: begin
                  state_in = ST_READ_WAIT;
               end
               ACT_FLIP: begin
                  state_in = ST_FLIP_WAIT;
               end
               ACT_GATE_ONE: begin
                  if (int'(target_ff) < int'(n_act)) begin
                     q_in     = NW'(target_ff);
                     cnt_in   = '0;
                     state_in = ST_GATE;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               ACT_GATE_ALL: begin
                  q_in     = '0;
                  cnt_in   = '0;
                  state_in = ST_GATE;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_READ_WAIT: begin
            res_re_in = FIELD_W'(rd_re);
            res_im_in = FIELD_W'(rd_im);
            state_in  = ST_RESP;
         end
         ST_FLIP_WAIT: begin
            amp_we    = 1'b1;
            amp_waddr = idx;
            amp_wdata = {sat_x(-ext_re), sat_x(-ext_im)};
            state_in  = ST_RESP;
         end
         // One amplitude pair per cycle enters the datapath.
         ST_GATE: begin
            amp_raddr_a     = cur & ~qmask;
            issue_tag.valid = 1'b1;
            issue_tag.row   = |(cur & qmask);
            if (cnt_ff == last_cnt) begin
               state_in = ST_GATE_DRAIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_GATE_DRAIN: begin
            if (!mac_busy) begin
               cnt_in   = '0;
               state_in = ST_COPY;
            end
         end
         // Scratch back to the amplitude memory, one entry per cycle.
         ST_COPY: begin
            copy_v_in    = 1'b1;
            copy_addr_in = cur;
            if (cnt_ff == last_cnt) begin
               state_in = ST_COPY_DRAIN;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_COPY_DRAIN: begin
            cnt_in = '0;
            if (act_ff == ACT_GATE_ALL && (int'(q_ff) + 1) < int'(n_act)) begin
               q_in     = q_ff + NW'(1);
               state_in = ST_GATE;
            end else begin
               q_in     = '0;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = res_re_ff;
               rsp_im_in    = res_im_ff;
               rsp_act_in   = act_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         q_ff         <= '0;
         nq_ff        <= NQ_RESET;
         copy_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
         nq_ff        <= nq_in;
         copy_v_ff    <= copy_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      target_ff    <= target_in;
      amp_re_ff    <= amp_re_in;
      amp_im_ff    <= amp_im_in;
      gate_ff      <= gate_in;
      res_re_ff    <= res_re_in;
      res_im_ff    <= res_im_in;
      copy_addr_ff <= copy_addr_in;
      rsp_re_ff    <= rsp_re_in;
      rsp_im_ff    <= rsp_im_in;
      rsp_act_ff   <= rsp_act_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_re      = rsp_re_ff;
   assign rsp_bus.out_im      = rsp_im_ff;
   assign rsp_bus.done_action = rsp_act_ff;
   assign gate                = gate_ff;

endmodule

`default_nettype wire

FILE: rtl/qubit_gate_state_update.sv
// Fixed-point state-vector engine: keeps 2^n complex Q2.14 amplitudes in an
// on-chip memory and applies loads, reads, phase flips and 2x2 gates to them.
// Items are handled one at a time. After reset all 2^MAX_QUBITS entries of
// the amplitude memory are swept to zero, one entry per cycle; no item is
// taken while the sweep runs. A gate on one qubit walks all 2^n entries
// through the two-stage multiply pipeline and then copies the scratch memory
// back; applying the gate to all qubits repeats that n times. The sweeps are
// paced by the single write port of each memory, which takes one entry per
// cycle.
// Depends on qgsu_pkg, the channel interfaces, qgsu_store, qgsu_mac, qgsu_ctrl.
`default_nettype none

module qubit_gate_state_update import qgsu_pkg::*; #(
   parameter int MAX_QUBITS = 10,
   parameter int AMP_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   qgsu_req_if.sink   req_bus,
   qgsu_rsp_if.source rsp_bus,
   qgsu_csr_if.sink   csr_bus
);

   localparam int ADDR_W = MAX_QUBITS;
   localparam int DW     = 2 * AMP_BITS;

   logic              amp_we;
   logic [ADDR_W-1:0] amp_waddr;
   logic [DW-1:0]     amp_wdata;
   logic [ADDR_W-1:0] amp_raddr_a;
   logic [ADDR_W-1:0] amp_raddr_b;
   logic [DW-1:0]     amp_rdata_a;
   logic [DW-1:0]     amp_rdata_b;
   logic              scr_we;
   logic [ADDR_W-1:0] scr_waddr;
   logic [DW-1:0]     scr_wdata;
   logic [ADDR_W-1:0] scr_raddr;
   logic [DW-1:0]     scr_rdata;
   mac_tag_type       issue_tag;
   logic [ADDR_W-1:0] issue_idx;
   gate_type          gate;
   logic              mac_busy;

   // Sequencer and channel handshakes.
   qgsu_ctrl #(
      .MAX_QUBITS (MAX_QUBITS),
      .AMP_BITS   (AMP_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .amp_we      (amp_we),
      .amp_waddr   (amp_waddr),
      .amp_wdata   (amp_wdata),
      .amp_raddr_a (amp_raddr_a),
      .amp_raddr_b (amp_raddr_b),
      .amp_rdata_a (amp_rdata_a),
      .scr_raddr   (scr_raddr),
      .scr_rdata   (scr_rdata),
      .issue_tag   (issue_tag),
      .issue_idx   (issue_idx),
      .gate        (gate),
      .mac_busy    (mac_busy)
   );

   // Gate arithmetic.
   qgsu_mac #(
      .MAX_QUBITS (MAX_QUBITS),
      .AMP_BITS   (AMP_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue_tag (issue_tag),
      .issue_idx (issue_idx),
      .gate      (gate),
      .s0_data   (amp_rdata_a),
      .s1_data   (amp_rdata_b),
      .busy      (mac_busy),
      .scr_we    (scr_we),
      .scr_waddr (scr_waddr),
      .scr_wdata (scr_wdata)
   );

   // Amplitude and scratch memories.
   qgsu_store #(
      .MAX_QUBITS (MAX_QUBITS),
      .AMP_BITS   (AMP_BITS)
   ) u_store (
      .clock       (clock),
      .amp_we      (amp_we),
      .amp_waddr   (amp_waddr),
      .amp_wdata   (amp_wdata),
      .amp_raddr_a (amp_raddr_a),
      .amp_raddr_b (amp_raddr_b),
      .amp_rdata_a (amp_rdata_a),
      .amp_rdata_b (amp_rdata_b),
      .scr_we      (scr_we),
      .scr_waddr   (scr_waddr),
      .scr_wdata   (scr_wdata),
      .scr_raddr   (scr_raddr),
      .scr_rdata   (scr_rdata)
   );

endmodule

`default_nettype wire

FILE: tb/qubit_gate_state_update_test.sv
// Testbench for the qubit gate state update block: random and directed items,
// a built-in amplitude predictor and a result checker.
// Depends on qgsu_pkg, the three channel interfaces and qubit_gate_state_update.
`default_nettype none

module qubit_gate_state_update_test;
   import qgsu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_SIZE = 1024;
   localparam int AMP_HI     = 32767;
   localparam int AMP_LO     = -32768;
   localparam int QMAX       = 10;
   localparam int WATCHDOG   = 200000;
   localparam field_type ONE    = 16'sd16384;
   localparam field_type INV_R2 = 16'sd11585;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [TARGET_W-1:0] target;
      field_type           amp_re;
      field_type           amp_im;
      gate_type            gate;
   } state_op_type;

   typedef struct {
      field_type           re;
      field_type           im;
      logic [ACTION_W-1:0] action;
   } readback_type;

   logic clock;
   logic reset;

   qgsu_req_if req_if ();
   qgsu_rsp_if rsp_if ();
   qgsu_csr_if csr_if ();

   qubit_gate_state_update uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source),
      .csr_bus (csr_if.sink)
   );

   // Predicted state vector and qubit count register.
   int              amp_re_mem [STORE_SIZE];
   int              amp_im_mem [STORE_SIZE];
   logic [NQ_W-1:0] qubit_count_reg;

   state_op_type pending_ops [$];
   readback_type readback_q [$];

   int   ops_queued;
   int   ops_taken;
   int   readbacks_seen;
   int   error_count;
   int   idle_cycles;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic req_fire;

   // Clock: 20 ns period.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int saturate(longint v);
      if (v > AMP_HI) return AMP_HI;
      if (v < AMP_LO) return AMP_LO;
      return int'(v);
   endfunction

   // Round half up to Q2.14, then saturate.
   function automatic int round_q14(longint acc);
      return saturate((acc + 64'sd8192) >>> FRAC_BITS);
   endfunction

   function automatic int active_qubits();
      if (qubit_count_reg < 1) return 1;
      if (qubit_count_reg > QMAX) return QMAX;
      return int'(qubit_count_reg);
   endfunction

   // One pass of the 2x2 gate over qubit q, all new values from the old state.
   function automatic void apply_gate_pass(gate_type g, int q, int n);
      longint gr [2][2];
      longint gi [2][2];
      int     new_re [STORE_SIZE];
      int     new_im [STORE_SIZE];
      int     m;
      int     b;
      int     s0;
      int     s1;
      longint acc_re;
      longint acc_im;
      gr[0][0] = g.g00.re; gi[0][0] = g.g00.im;
      gr[0][1] = g.g01.re; gi[0][1] = g.g01.im;
      gr[1][0] = g.g10.re; gi[1][0] = g.g10.im;
      gr[1][1] = g.g11.re; gi[1][1] = g.g11.im;
      m = 1 << (n - 1 - q);
      for (int i = 0; i < (1 << n); i++) begin
         b  = ((i & m) != 0) ? 1 : 0;
         s0 = i & ~m;
         s1 = i | m;
         acc_re = gr[b][0] * amp_re_mem[s0] - gi[b][0] * amp_im_mem[s0]
                + gr[b][1] * amp_re_mem[s1] - gi[b][1] * amp_im_mem[s1];
         acc_im = gr[b][0] * amp_im_mem[s0] + gi[b][0] * amp_re_mem[s0]
                + gr[b][1] * amp_im_mem[s1] + gi[b][1] * amp_re_mem[s1];
         new_re[i] = round_q14(acc_re);
         new_im[i] = round_q14(acc_im);
      end
      for (int i = 0; i < (1 << n); i++) begin
         amp_re_mem[i] = new_re[i];
         amp_im_mem[i] = new_im[i];
      end
   endfunction

   // Update the predicted state with one operation and return its readback.
   function automatic readback_type predict_readback(state_op_type op);
      readback_type rb;
      int           n;
      int           idx;
      n   = active_qubits();
      idx = int'(op.target) & ((1 << n) - 1);
      rb.re     = '0;
      rb.im     = '0;
      rb.action = op.action;
      case (op.action)
         ACT_LOAD: begin
            amp_re_mem[idx] = op.amp_re;
            amp_im_mem[idx] = op.amp_im;
         end
         ACT_READ: begin
            rb.re = field_type'(amp_re_mem[idx]);
            rb.im = field_type'(amp_im_mem[idx]);
         end
         ACT_GATE_ONE: begin
            if (int'(op.target) < n) apply_gate_pass(op.gate, int'(op.target), n);
         end
         ACT_GATE_ALL: begin
            for (int q = 0; q < n; q++) apply_gate_pass(op.gate, q, n);
         end
         ACT_FLIP: begin
            amp_re_mem[idx] = saturate(-longint'(amp_re_mem[idx]));
            amp_im_mem[idx] = saturate(-longint'(amp_im_mem[idx]));
         end
         default: ;
      endcase
      return rb;
   endfunction

   function automatic coef_type coef(int re, int im);
      coef_type c;
      c.re = field_type'(re);
      c.im = field_type'(im);
      return c;
   endfunction

   function automatic gate_type make_gate(coef_type a, coef_type b, coef_type c,
                                          coef_type d);
      gate_type g;
      g.g00 = a;
      g.g01 = b;
      g.g10 = c;
      g.g11 = d;
      return g;
   endfunction

   function automatic state_op_type make_op(logic [ACTION_W-1:0] action, int target,
                                            int re, int im, gate_type g);
      state_op_type op;
      op.action = action;
      op.target = TARGET_W'(target);
      op.amp_re = field_type'(re);
      op.amp_im = field_type'(im);
      op.gate   = g;
      return op;
   endfunction

   function automatic int rand_amp();
      case ($urandom_range(5))
         0: return AMP_HI;
         1: return AMP_LO;
         2: return $urandom_range(0, 8192) - 4096;
         3: return $urandom_range(0, 32768) - 16384;
         default: return int'(field_type'($urandom));
      endcase
   endfunction

   function automatic coef_type rand_coef(int span);
      return coef($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
   endfunction

   // Mostly unitary-looking gates, with scaled and unbounded ones mixed in.
   function automatic gate_type rand_gate();
      coef_type z;
      z = coef(0, 0);
      case ($urandom_range(6))
         0: return make_gate(coef(INV_R2, 0), coef(INV_R2, 0), coef(INV_R2, 0),
                             coef(-INV_R2, 0));
         1: return make_gate(coef(ONE, 0), z, z, coef(ONE, 0));
         2: return make_gate(z, coef(ONE, 0), coef(ONE, 0), z);
         3: return make_gate(coef(ONE, 0), z, z, coef(0, ONE));
         4: return make_gate(rand_coef(11585), rand_coef(11585), rand_coef(11585),
                             rand_coef(11585));
         default: return make_gate(coef(rand_amp(), rand_amp()), coef(rand_amp(), rand_amp()),
                                   coef(rand_amp(), rand_amp()), coef(rand_amp(), rand_amp()));
      endcase
   endfunction

   function automatic state_op_type rand_op(int n, int gate_pct);
      int                  r;
      logic [ACTION_W-1:0] action;
      int                  target;
      r      = $urandom_range(99);
      target = $urandom_range(STORE_SIZE - 1);
      if (r < gate_pct) begin
         if ($urandom_range(3) == 0) begin
            action = ACT_GATE_ALL;
         end else begin
            action = ACT_GATE_ONE;
            if ($urandom_range(5) != 0) target = $urandom_range(n - 1);
         end
      end else if (r < gate_pct + 30) begin
         action = ACT_LOAD;
      end else if (r < gate_pct + 60) begin
         action = ACT_READ;
      end else if (r < 96) begin
         action = ACT_FLIP;
      end else begin
         action = ACTION_W'($urandom_range(5, 7));
      end
      return make_op(action, target, rand_amp(), rand_amp(), rand_gate());
   endfunction

   task automatic queue_op(state_op_type op);
      pending_ops.push_back(op);
      ops_queued++;
   endtask

   // Blocks until every queued operation has been taken and answered.
   task automatic wait_drained();
      while (!(ops_taken == ops_queued && readbacks_seen == ops_taken)) @(posedge clock);
   endtask

   task automatic write_qubit_count(int value);
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.num_qubits <= NQ_W'(value);
      do @(posedge clock); while (!csr_if.ready);
      qubit_count_reg = NQ_W'(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Request driver: next beat from the pending queue once the last is taken, plus result ready.
   always @(negedge clock) begin
      state_op_type op;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            op = pending_ops.pop_front();
            req_if.valid  <= 1'b1;
            req_if.action <= op.action;
            req_if.target <= op.target;
            req_if.amp_re <= op.amp_re;
            req_if.amp_im <= op.amp_im;
            req_if.g00_re <= op.gate.g00.re;
            req_if.g00_im <= op.gate.g00.im;
            req_if.g01_re <= op.gate.g01.re;
            req_if.g01_im <= op.gate.g01.im;
            req_if.g10_re <= op.gate.g10.re;
            req_if.g10_im <= op.gate.g10.im;
            req_if.g11_re <= op.gate.g11.re;
            req_if.g11_im <= op.gate.g11.im;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predict on each request beat, check each result beat.
   always @(posedge clock) begin
      state_op_type op;
      readback_type want;
      logic         req_beat;
      logic         rsp_beat;
      req_beat = req_if.valid && req_if.ready && !reset;
      rsp_beat = rsp_if.valid && rsp_if.ready && !reset;
      req_fire <= req_beat;
      if (req_beat) begin
         op.action       = req_if.action;
         op.target       = req_if.target;
         op.amp_re       = req_if.amp_re;
         op.amp_im       = req_if.amp_im;
         op.gate.g00.re  = req_if.g00_re;
         op.gate.g00.im  = req_if.g00_im;
         op.gate.g01.re  = req_if.g01_re;
         op.gate.g01.im  = req_if.g01_im;
         op.gate.g10.re  = req_if.g10_re;
         op.gate.g10.im  = req_if.g10_im;
         op.gate.g11.re  = req_if.g11_re;
         op.gate.g11.im  = req_if.g11_im;
         readback_q.push_back(predict_readback(op));
         ops_taken <= ops_taken + 1;
      end
      if (rsp_beat) begin
         readbacks_seen <= readbacks_seen + 1;
         if (readback_q.size() == 0) begin
            $display("%t: unexpected result beat re=%0d im=%0d action=%0d", $realtime,
                     rsp_if.out_re, rsp_if.out_im, rsp_if.done_action);
            error_count++;
         end else begin
            want = readback_q.pop_front();
            if (rsp_if.out_re !== want.re) begin
               $display("%t: out_re expected %0d actual %0d", $realtime, want.re,
                        rsp_if.out_re);
               error_count++;
            end
            if (rsp_if.out_im !== want.im) begin
               $display("%t: out_im expected %0d actual %0d", $realtime, want.im,
                        rsp_if.out_im);
               error_count++;
            end
            if (rsp_if.done_action !== want.action) begin
               $display("%t: done_action expected %0d actual %0d", $realtime,
                        want.action, rsp_if.done_action);
               error_count++;
            end
         end
      end
      // Watchdog on cycles with no beat on any channel.
      if (reset || req_beat || rsp_beat || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("qubit_gate_state_update_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed items at reset size, then random phases.
   initial begin
      gate_type  had;
      gate_type  ident;
      gate_type  wild;
      int        phase_nq [10];
      int        phase_len [10];
      int        n;
      int        gate_pct;
      phase_nq  = '{3, 1, 4, 2, 0, 5, 15, 10, 2, 1};
      phase_len = '{35, 25, 35, 30, 15, 25, 10, 15, 30, 20};
      had   = make_gate(coef(INV_R2, 0), coef(INV_R2, 0), coef(INV_R2, 0), coef(-INV_R2, 0));
      ident = make_gate(coef(ONE, 0), coef(0, 0), coef(0, 0), coef(ONE, 0));
      wild  = make_gate(coef(AMP_LO, AMP_HI), coef(AMP_HI, AMP_LO), coef(AMP_LO, AMP_LO),
                        coef(AMP_HI, AMP_HI));

      req_if.valid  = 1'b0;
      req_if.action = ACT_READ;
      req_if.target = '0;
      req_if.amp_re = '0;
      req_if.amp_im = '0;
      req_if.g00_re = '0;
      req_if.g00_im = '0;
      req_if.g01_re = '0;
      req_if.g01_im = '0;
      req_if.g10_re = '0;
      req_if.g10_im = '0;
      req_if.g11_re = '0;
      req_if.g11_im = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.num_qubits = '0;
      qubit_count_reg   = NQ_RESET;
      for (int i = 0; i < STORE_SIZE; i++) begin
         amp_re_mem[i] = 0;
         amp_im_mem[i] = 0;
      end
      ops_queued     = 0;
      ops_taken      = 0;
      readbacks_seen = 0;
      error_count    = 0;
      idle_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      req_fire       = 1'b0;
      reset          = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: cleared store, extremes, saturating flip, undefined actions, gates.
      queue_op(make_op(ACT_READ, 0, 0, 0, ident));
      queue_op(make_op(ACT_READ, 1023, 0, 0, ident));
      queue_op(make_op(ACT_LOAD, 0, AMP_HI, AMP_LO, wild));
      queue_op(make_op(ACT_LOAD, 1023, AMP_LO, AMP_HI, ident));
      queue_op(make_op(ACT_READ, 0, 0, 0, wild));
      queue_op(make_op(ACT_FLIP, 0, 0, 0, ident));
      queue_op(make_op(ACT_READ, 0, 0, 0, ident));
      queue_op(make_op(ACT_FLIP, 1023, 0, 0, ident));
      queue_op(make_op(ACT_READ, 1023, 0, 0, ident));
      queue_op(make_op(ACT_LOAD, 512, ONE, 0, ident));
      queue_op(make_op(3'd5, 512, AMP_HI, AMP_HI, wild));
      queue_op(make_op(3'd7, 1023, 0, 0, ident));
      queue_op(make_op(ACT_READ, 512, 0, 0, ident));
      queue_op(make_op(ACT_GATE_ONE, 0, 0, 0, had));
      queue_op(make_op(ACT_GATE_ONE, 9, 0, 0, had));
      queue_op(make_op(ACT_GATE_ONE, 1023, 0, 0, wild));
      queue_op(make_op(ACT_GATE_ONE, 10, 0, 0, wild));
      queue_op(make_op(ACT_READ, 0, 0, 0, ident));
      queue_op(make_op(ACT_READ, 1, 0, 0, ident));
      queue_op(make_op(ACT_GATE_ALL, 0, 0, 0, wild));
      queue_op(make_op(ACT_READ, 0, 0, 0, ident));
      queue_op(make_op(ACT_READ, 1023, 0, 0, ident));
      wait_drained();
      repeat (20) @(posedge clock);

      // Random phases; each sets a qubit count and one of four idling patterns.
      for (int p = 0; p < 10; p++) begin
         write_qubit_count(phase_nq[p]);
         n        = active_qubits();
         gate_pct = (n >= 8) ? 3 : 20;
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         // Short burst of loads so gates act on a populated state.
         for (int i = 0; i < (1 << n) && i < 4; i++)
            queue_op(make_op(ACT_LOAD, i, rand_amp(), rand_amp(), ident));
         for (int i = 0; i < phase_len[p]; i++) begin
            queue_op(rand_op(n, gate_pct));
            // Sender holds off mid-phase until all results are back.
            if (p == 2 && i == phase_len[p] / 2) begin
               wait_drained();
            end
         end
         wait_drained();
         repeat (20) @(posedge clock);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && readback_q.size() == 0) begin
         $display("qubit_gate_state_update_test passed");
      end else begin
         $display("qubit_gate_state_update_test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/qgsu_pkg.sv
rtl/qgsu_req_if.sv
rtl/qgsu_rsp_if.sv
rtl/qgsu_csr_if.sv
rtl/qgsu_store.sv
rtl/qgsu_mac.sv
rtl/qgsu_ctrl.sv
rtl/qubit_gate_state_update.sv
tb/qubit_gate_state_update_test.sv
